[rtl/rtcc_pkg.sv]
// Package for the real-time clock channel: widths, codes, register indexes,
// request and response types, and the status structs passed between modules.
// Has no dependencies; every other file refers to it by scoped names.
package rtcc_pkg;

	localparam int CLOCK_W       = 32;
	localparam int HOST_W        = 64;
	localparam int PEND_W        = 56;
	localparam int RATE_W        = 32;
	localparam int QUOT_W        = 16;
	localparam int INCR_W        = 8;
	localparam int DATA_W        = 12;
	localparam int FRACTION_BITS = 8;
	localparam int DIGIT_W       = FRACTION_BITS;
	localparam int HOST_DIGITS   = HOST_W / DIGIT_W;
	localparam int PEND_DIGITS   = PEND_W / DIGIT_W;
	localparam int DIGIT_CNT_W   = $clog2(HOST_DIGITS);
	localparam int DIVSR_W       = RATE_W + QUOT_W - 1;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [DIGIT_CNT_W-1:0] ADD_LAST = DIGIT_CNT_W'(PEND_DIGITS - 2);
	localparam logic [DIGIT_CNT_W-1:0] CNT_LAST = DIGIT_CNT_W'(HOST_DIGITS - 1);
	localparam logic [PEND_W-1:0]      PEND_MAX = {PEND_W{1'b1}};

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAP       = 2'd3;

	typedef struct packed {
		logic              func;
		logic [HOST_W-1:0] host_ticks;
	} req_t;

	typedef struct packed {
		logic [CLOCK_W-1:0] clock_value;
		logic [DATA_W-1:0]  channel_data;
		logic               channel_full;
	} rsp_t;

	typedef struct packed {
		logic [INCR_W-1:0] increment;
		logic [RATE_W-1:0] ticks_per_us_q8;
		logic              full_flag;
		logic [QUOT_W-1:0] max_us_per_read;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic [PEND_W-1:0] pending;
	} acc_stat_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic [PEND_W-1:0] rem;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

endpackage

[rtl/realtime_clock_channel.sv]
// Top level of the real-time clock channel: control sequencer, clock counter
// and response register. Uses rtcc_pkg, rtcc_regs, rtcc_accum and rtcc_div.
//
// Usage: requests arrive on req_valid/req_stall with a req_t payload; every
// request yields exactly one response on rsp_valid/rsp_stall. A tick request
// (func 0) adds the increment register to the clock. A read request (func 1)
// with increment zero moves elapsed host time, in whole microseconds up to
// max_us_per_read, into the clock; any other read leaves the clock alone.
// The block works on one request at a time and holds req_stall high while busy.
// Ticks and untimed reads go straight to the FINISH state, which loads the response.
// A timed read goes through the ACCUM state for the byte-serial tick difference
// and pending add, the DIVIDE state for the one-bit-per-cycle capped divide,
// and the FINISH state, which loads the response.
// The next request is taken in the cycle after the response is loaded, even
// if that response still waits downstream; a stalled response holds.
// Write registers over cfg_we/cfg_index/cfg_data only while idle (unenforced).
// Reset clears the clock and read tracking and restores register defaults.
module realtime_clock_channel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  rtcc_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output rtcc_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [rtcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtcc_pkg::CFG_DATA_W-1:0] cfg_data
);

	rtcc_pkg::cfg_t      cfg;
	rtcc_pkg::acc_stat_t acc_stat;
	rtcc_pkg::div_res_t  div_res;
	rtcc_pkg::state_t    state_q;
	rtcc_pkg::state_t    state_next;
	logic [rtcc_pkg::CLOCK_W-1:0] clock_q;
	logic                rsp_valid_q;
	rtcc_pkg::rsp_t      rsp_q;
	logic                timed;
	logic                accept;
	logic                acc_start;
	logic                div_start;
	logic                rsp_load;

	rtcc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rtcc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (acc_start),
		.host_ticks (req.host_ticks),
		.load_rem   (div_res.done),
		.rem        (div_res.rem),
		.stat       (acc_stat)
	);

	rtcc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.pending (acc_stat.pending),
		.rate    (cfg.ticks_per_us_q8),
		.cap     (cfg.max_us_per_read),
		.res     (div_res)
	);

	assign timed = (req.func == rtcc_pkg::FUNC_READ) && (cfg.increment == '0);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rtcc_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_next = timed ? rtcc_pkg::ST_ACCUM : rtcc_pkg::ST_FINISH;
				end
			end
			rtcc_pkg::ST_ACCUM: begin
				if (acc_stat.done) begin
					state_next = rtcc_pkg::ST_DIVIDE;
				end
			end
			rtcc_pkg::ST_DIVIDE: begin
				if (div_res.done) begin
					state_next = rtcc_pkg::ST_FINISH;
				end
			end
			rtcc_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_next = rtcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = rtcc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != rtcc_pkg::ST_IDLE);
		accept    = (state_q == rtcc_pkg::ST_IDLE) && req_valid;
		acc_start = accept && timed;
		div_start = (state_q == rtcc_pkg::ST_ACCUM) && acc_stat.done;
		rsp_load  = (state_q == rtcc_pkg::ST_FINISH) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtcc_pkg::ST_IDLE;
			clock_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept && (req.func == rtcc_pkg::FUNC_TICK)) begin
				clock_q <= clock_q + {{(rtcc_pkg::CLOCK_W - rtcc_pkg::INCR_W){1'b0}},
					cfg.increment};
			end else if ((state_q == rtcc_pkg::ST_DIVIDE) && div_res.done) begin
				clock_q <= clock_q + {{(rtcc_pkg::CLOCK_W - rtcc_pkg::QUOT_W){1'b0}},
					div_res.quot};
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.clock_value  <= clock_q;
			rsp_q.channel_data <= clock_q[rtcc_pkg::DATA_W-1:0];
			rsp_q.channel_full <= cfg.full_flag;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/rtcc_regs.sv]
// Configuration register file of the real-time clock channel.
// Depends on rtcc_pkg for the register indexes and the cfg_t struct.
module rtcc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rtcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtcc_pkg::CFG_DATA_W-1:0] cfg_data,
	output rtcc_pkg::cfg_t                 cfg
);

	rtcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.increment       <= rtcc_pkg::INCR_W'(1);
			cfg_q.ticks_per_us_q8 <= rtcc_pkg::RATE_W'(256);
			cfg_q.full_flag       <= 1'b0;
			cfg_q.max_us_per_read <= rtcc_pkg::QUOT_W'(400);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtcc_pkg::REG_INCREMENT: begin
					cfg_q.increment <= cfg_data[rtcc_pkg::INCR_W-1:0];
				end
				rtcc_pkg::REG_RATE: begin
					cfg_q.ticks_per_us_q8 <= cfg_data[rtcc_pkg::RATE_W-1:0];
				end
				rtcc_pkg::REG_FULL: begin
					cfg_q.full_flag <= cfg_data[0];
				end
				rtcc_pkg::REG_CAP: begin
					cfg_q.max_us_per_read <= cfg_data[rtcc_pkg::QUOT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/rtcc_accum.sv]
// Digit-serial tick accumulator: forms the host tick difference one byte per
// cycle and adds it, scaled, into the saturating pending store. Uses rtcc_pkg.
module rtcc_accum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rtcc_pkg::HOST_W-1:0] host_ticks,
	input  logic                        load_rem,
	input  logic [rtcc_pkg::PEND_W-1:0] rem,
	output rtcc_pkg::acc_stat_t         stat
);

	logic                                seen_q;
	logic [rtcc_pkg::HOST_W-1:0]         last_q;
	logic [rtcc_pkg::PEND_W-1:0]         pend_q;
	logic [rtcc_pkg::HOST_W-1:0]         now_sr_q;
	logic [rtcc_pkg::HOST_W-1:0]         last_sr_q;
	logic [rtcc_pkg::PEND_W-1:0]         pend_sr_q;
	logic                                borrow_q;
	logic                                carry_q;
	logic                                sat_q;
	logic [rtcc_pkg::DIGIT_CNT_W-1:0]    cnt_q;
	logic                                run_q;
	logic                                done_q;
	logic [rtcc_pkg::DIGIT_W:0]          dif9;
	logic [rtcc_pkg::DIGIT_W:0]          sum9;
	logic                                add_phase;
	logic                                sat_next;

	assign dif9 = {1'b0, now_sr_q[rtcc_pkg::DIGIT_W-1:0]}
		- {1'b0, last_sr_q[rtcc_pkg::DIGIT_W-1:0]}
		- {{rtcc_pkg::DIGIT_W{1'b0}}, borrow_q};
	assign sum9 = {1'b0, pend_sr_q[rtcc_pkg::DIGIT_W-1:0]}
		+ {1'b0, dif9[rtcc_pkg::DIGIT_W-1:0]}
		+ {{rtcc_pkg::DIGIT_W{1'b0}}, carry_q};
	assign add_phase = (cnt_q <= rtcc_pkg::ADD_LAST);
	assign sat_next  = sat_q | (add_phase
		? ((cnt_q == rtcc_pkg::ADD_LAST) && sum9[rtcc_pkg::DIGIT_W])
		: (dif9[rtcc_pkg::DIGIT_W-1:0] != '0));

	// The difference digit k lines up with pending digit k+1, so the store
	// is rotated one digit before the pass and lands back in order after it.
	always_ff @(posedge clk) begin
		if (start) begin
			now_sr_q  <= host_ticks;
			last_sr_q <= seen_q ? last_q : host_ticks;
			pend_sr_q <= {pend_q[rtcc_pkg::DIGIT_W-1:0],
				pend_q[rtcc_pkg::PEND_W-1:rtcc_pkg::DIGIT_W]};
			borrow_q  <= 1'b0;
			carry_q   <= 1'b0;
			sat_q     <= 1'b0;
		end else if (run_q) begin
			now_sr_q  <= now_sr_q >> rtcc_pkg::DIGIT_W;
			last_sr_q <= last_sr_q >> rtcc_pkg::DIGIT_W;
			borrow_q  <= dif9[rtcc_pkg::DIGIT_W];
			sat_q     <= sat_next;
			if (add_phase) begin
				pend_sr_q <= {sum9[rtcc_pkg::DIGIT_W-1:0],
					pend_sr_q[rtcc_pkg::PEND_W-1:rtcc_pkg::DIGIT_W]};
				carry_q   <= sum9[rtcc_pkg::DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
			pend_q <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				seen_q <= 1'b1;
				last_q <= host_ticks;
				cnt_q  <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rtcc_pkg::CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
					pend_q <= sat_next ? rtcc_pkg::PEND_MAX : pend_sr_q;
				end
			end else if (load_rem) begin
				pend_q <= rem;
			end
		end
	end

	assign stat.done    = done_q;
	assign stat.pending = pend_q;

endmodule

[rtl/rtcc_div.sv]
// Bit-serial restoring divider whose quotient is limited to a cap: one
// quotient bit per cycle, yielding the quotient and the remainder. Uses rtcc_pkg.
module rtcc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rtcc_pkg::PEND_W-1:0] pending,
	input  logic [rtcc_pkg::RATE_W-1:0] rate,
	input  logic [rtcc_pkg::QUOT_W-1:0] cap,
	output rtcc_pkg::div_res_t          res
);

	logic [rtcc_pkg::PEND_W-1:0]  rem_q;
	logic [rtcc_pkg::DIVSR_W-1:0] divsr_q;
	logic [rtcc_pkg::QUOT_W-1:0]  mask_q;
	logic [rtcc_pkg::QUOT_W-1:0]  quot_q;
	logic                         run_q;
	logic                         done_q;
	logic [rtcc_pkg::RATE_W-1:0]  rate_eff;
	logic [rtcc_pkg::QUOT_W-1:0]  cand;
	logic [rtcc_pkg::PEND_W-1:0]  divsr_ext;
	logic                         fits;

	assign rate_eff  = (rate == '0) ? rtcc_pkg::RATE_W'(1) : rate;
	assign cand      = quot_q | mask_q;
	assign divsr_ext = {{(rtcc_pkg::PEND_W - rtcc_pkg::DIVSR_W){1'b0}}, divsr_q};
	// A bit is kept only if the partial quotient stays within the cap, which
	// yields the smaller of the true quotient and the cap.
	assign fits      = (divsr_ext <= rem_q) && (cand <= cap);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= pending;
			divsr_q <= {rate_eff, {(rtcc_pkg::QUOT_W - 1){1'b0}}};
			mask_q  <= {1'b1, {(rtcc_pkg::QUOT_W - 1){1'b0}}};
			quot_q  <= '0;
		end else if (run_q) begin
			divsr_q <= divsr_q >> 1;
			mask_q  <= mask_q >> 1;
			if (fits) begin
				rem_q  <= rem_q - divsr_ext;
				quot_q <= cand;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && mask_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

[rtl/rtcc_checker.sv]
// Port-level checker for the real-time clock channel and its bind statement.
// Depends on rtcc_pkg for the payload types; attaches to realtime_clock_channel.
module rtcc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input rtcc_pkg::rsp_t rsp
);

	// A stalled response must hold its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// The channel data is always the low bits of the clock it came with.
	a_rsp_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.channel_data == rsp.clock_value[rtcc_pkg::DATA_W-1:0])
		else $error("channel data does not match clock value");

	// Only one request is in work at a time.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");

endmodule

bind realtime_clock_channel rtcc_checker u_checker (.*);

[bench/tb_top.sv]
// Self-checking testbench for realtime_clock_channel: a table of directed
// requests, then randomized register phases, checked by hand or by a clock model.
// Depends on rtcc_pkg and the realtime_clock_channel RTL only.
module tb_top;

	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int QUIET_LIMIT     = 2000;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		logic                            is_write;
		logic [rtcc_pkg::CFG_IDX_W-1:0]  reg_index;
		logic [rtcc_pkg::CFG_DATA_W-1:0] reg_value;
		rtcc_pkg::req_t                  item;
		logic                            known;
		rtcc_pkg::rsp_t                  known_rsp;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	rtcc_pkg::req_t                  req;
	logic                            rsp_valid;
	logic                            rsp_stall;
	rtcc_pkg::rsp_t                  rsp;
	logic                            cfg_we;
	logic [rtcc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rtcc_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [rtcc_pkg::INCR_W-1:0]  m_incr;
	logic [rtcc_pkg::RATE_W-1:0]  m_rate;
	logic                         m_full;
	logic [rtcc_pkg::QUOT_W-1:0]  m_cap;
	logic [rtcc_pkg::CLOCK_W-1:0] m_clock;
	logic [rtcc_pkg::HOST_W-1:0]  m_last_ticks;
	logic                         m_seen_read;
	logic [rtcc_pkg::PEND_W-1:0]  m_pending;

	rtcc_pkg::rsp_t expected_rsps[$];
	stim_row_t      stim_table[$];
	int unsigned    mismatch_count;
	int unsigned    quiet_cycles;
	int unsigned    stall_mode;
	int unsigned    stall_left;

	realtime_clock_channel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rtcc_pkg::rsp_t step_clock_model(rtcc_pkg::req_t r);
		logic [rtcc_pkg::HOST_W-1:0] elapsed;
		logic [rtcc_pkg::HOST_W-1:0] divisor;
		logic [rtcc_pkg::HOST_W-1:0] whole_us;
		logic [rtcc_pkg::PEND_W:0]   sum;
		rtcc_pkg::rsp_t              o;
		if (r.func == rtcc_pkg::FUNC_TICK) begin
			m_clock = m_clock + rtcc_pkg::CLOCK_W'(m_incr);
		end else if (m_incr == '0) begin
			if (!m_seen_read) begin
				m_seen_read  = 1'b1;
				m_last_ticks = r.host_ticks;
			end
			elapsed      = r.host_ticks - m_last_ticks;
			m_last_ticks = r.host_ticks;
			if (elapsed > rtcc_pkg::HOST_W'(rtcc_pkg::PEND_MAX >> rtcc_pkg::FRACTION_BITS))
					begin
				m_pending = rtcc_pkg::PEND_MAX;
			end else begin
				sum       = {1'b0, m_pending}
					+ (rtcc_pkg::PEND_W + 1)'(elapsed << rtcc_pkg::FRACTION_BITS);
				m_pending = (sum > {1'b0, rtcc_pkg::PEND_MAX})
					? rtcc_pkg::PEND_MAX : sum[rtcc_pkg::PEND_W-1:0];
			end
			divisor  = (m_rate == '0) ? rtcc_pkg::HOST_W'(1) : rtcc_pkg::HOST_W'(m_rate);
			whole_us = rtcc_pkg::HOST_W'(m_pending) / divisor;
			if (whole_us > rtcc_pkg::HOST_W'(m_cap))
				whole_us = rtcc_pkg::HOST_W'(m_cap);
			m_pending = m_pending - rtcc_pkg::PEND_W'(whole_us * divisor);
			m_clock   = m_clock + rtcc_pkg::CLOCK_W'(whole_us);
		end
		o.clock_value  = m_clock;
		o.channel_data = m_clock[rtcc_pkg::DATA_W-1:0];
		o.channel_full = m_full;
		return o;
	endfunction

	function automatic void table_item(logic func, logic [rtcc_pkg::HOST_W-1:0] ticks);
		stim_row_t row;
		row = '{1'b0, '0, '0, '{func, ticks}, 1'b0, '0};
		stim_table.push_back(row);
	endfunction

	function automatic void table_item_known(logic func,
			logic [rtcc_pkg::HOST_W-1:0] ticks,
			logic [rtcc_pkg::CLOCK_W-1:0] clock_after, logic full);
		stim_row_t row;
		row = '{1'b0, '0, '0, '{func, ticks}, 1'b1,
			'{clock_after, clock_after[rtcc_pkg::DATA_W-1:0], full}};
		stim_table.push_back(row);
	endfunction

	function automatic void table_write(logic [rtcc_pkg::CFG_IDX_W-1:0] idx,
			logic [rtcc_pkg::CFG_DATA_W-1:0] value);
		stim_row_t row;
		row = '{1'b1, idx, value, '0, 1'b0, '0};
		stim_table.push_back(row);
	endfunction

	task automatic write_reg(logic [rtcc_pkg::CFG_IDX_W-1:0] idx,
			logic [rtcc_pkg::CFG_DATA_W-1:0] value);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rtcc_pkg::REG_INCREMENT: m_incr = value[rtcc_pkg::INCR_W-1:0];
			rtcc_pkg::REG_RATE:      m_rate = value[rtcc_pkg::RATE_W-1:0];
			rtcc_pkg::REG_FULL:      m_full = value[0];
			rtcc_pkg::REG_CAP:       m_cap  = value[rtcc_pkg::QUOT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_request(rtcc_pkg::req_t r, int unsigned gap, logic known,
			rtcc_pkg::rsp_t known_rsp);
		rtcc_pkg::rsp_t predicted;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		predicted = step_clock_model(r);
		expected_rsps.push_back(known ? known_rsp : predicted);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : response_side
		rtcc_pkg::rsp_t want;
		logic           next_stall;
		if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("Unexpected response: clock %h data %h full %b",
						rsp.clock_value, rsp.channel_data, rsp.channel_full);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.clock_value !== want.clock_value
						|| rsp.channel_data !== want.channel_data
						|| rsp.channel_full !== want.channel_full) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"Bad response: expected clock %h data %h full %b, ",
							"got clock %h data %h full %b"},
							want.clock_value, want.channel_data, want.channel_full,
							rsp.clock_value, rsp.channel_data, rsp.channel_full);
				end
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: next_stall = 1'b0;
			1: next_stall = ($urandom_range(0, 2) == 0);
			2: next_stall = ($urandom_range(0, 7) != 0);
			default: next_stall = ~rsp_stall;
		endcase
		if (!arst_n)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= next_stall;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("realtime_clock_channel: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		rtcc_pkg::cfg_t              phase_cfg;
		rtcc_pkg::req_t              r;
		int unsigned                 gap;
		int unsigned                 burst_left;
		logic [rtcc_pkg::HOST_W-1:0] host_cursor;
		logic [rtcc_pkg::HOST_W-1:0] delta;
		int unsigned                 pick;

		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		burst_left     = 0;
		host_cursor    = '0;

		m_incr       = rtcc_pkg::INCR_W'(1);
		m_rate       = rtcc_pkg::RATE_W'(256);
		m_full       = 1'b0;
		m_cap        = rtcc_pkg::QUOT_W'(400);
		m_clock      = '0;
		m_last_ticks = '0;
		m_seen_read  = 1'b0;
		m_pending    = '0;

		// With the reset rate of one microsecond per host tick, the first reads in
		// microsecond mode can be worked out by hand, including the per-read cap.
		table_item_known(rtcc_pkg::FUNC_READ, 64'h0000_0000_0000_3039, 32'd0, 1'b0);
		table_item_known(rtcc_pkg::FUNC_TICK, '0, 32'd1, 1'b0);
		table_item_known(rtcc_pkg::FUNC_TICK, '1, 32'd2, 1'b0);
		table_write(rtcc_pkg::REG_INCREMENT, 32'd0);
		table_item_known(rtcc_pkg::FUNC_TICK, 64'd77, 32'd2, 1'b0);
		table_item_known(rtcc_pkg::FUNC_READ, 64'd1000, 32'd2, 1'b0);
		table_item_known(rtcc_pkg::FUNC_READ, 64'd1100, 32'd102, 1'b0);
		table_item_known(rtcc_pkg::FUNC_READ, 64'd2100, 32'd502, 1'b0);
		table_item_known(rtcc_pkg::FUNC_READ, 64'd2100, 32'd902, 1'b0);
		table_item_known(rtcc_pkg::FUNC_READ, 64'd2100, 32'd1102, 1'b0);
		table_item(rtcc_pkg::FUNC_READ, 64'd2100);
		table_write(rtcc_pkg::REG_RATE, 32'd0);
		table_item(rtcc_pkg::FUNC_READ, 64'd2101);
		table_item(rtcc_pkg::FUNC_READ, 64'd0);
		table_write(rtcc_pkg::REG_CAP, 32'd0);
		table_item(rtcc_pkg::FUNC_READ, 64'd10);
		table_write(rtcc_pkg::REG_CAP, 32'h0000_FFFF);
		table_write(rtcc_pkg::REG_RATE, 32'hFFFF_FFFF);
		table_item(rtcc_pkg::FUNC_READ, '1);
		table_item(rtcc_pkg::FUNC_READ, 64'h8000_0000_0000_0000);
		table_write(rtcc_pkg::REG_FULL, 32'd1);
		table_item(rtcc_pkg::FUNC_READ, 64'h8000_0000_0000_0100);
		table_write(rtcc_pkg::REG_INCREMENT, 32'd255);
		table_item(rtcc_pkg::FUNC_TICK, 64'h5555_5555_5555_5555);
		table_item(rtcc_pkg::FUNC_READ, 64'hAAAA_AAAA_AAAA_AAAA);
		table_item(rtcc_pkg::FUNC_TICK, 64'h0123_4567_89AB_CDEF);
		table_write(rtcc_pkg::REG_FULL, 32'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < stim_table.size(); i++) begin
			if (stim_table[i].is_write) begin
				write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
			end else begin
				gap = $urandom_range(0, 2);
				if (i + 1 == stim_table.size() || stim_table[i + 1].is_write)
					gap = 1;
				send_request(stim_table[i].item, gap, stim_table[i].known,
					stim_table[i].known_rsp);
			end
		end

		host_cursor = {$urandom(), $urandom()};
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_cfg = '{8'd0, 32'd256, 1'b1, 16'd400};
				1: phase_cfg = '{8'd0, 32'd1, 1'b0, 16'hFFFF};
				2: phase_cfg = '{8'd0, 32'hFFFF_FFFF, 1'b1, 16'd1};
				3: phase_cfg = '{8'd255, $urandom(), 1'b0, 16'($urandom())};
				4: phase_cfg = '{8'd0, 32'd0, 1'b1, 16'($urandom_range(1, 2000))};
				5: phase_cfg = '{8'd0, 32'($urandom_range(1, 4096)), 1'b0, 16'd0};
				default: begin
					phase_cfg.increment = ($urandom_range(0, 3) == 0)
						? 8'($urandom_range(1, 255)) : 8'd0;
					phase_cfg.ticks_per_us_q8 = ($urandom_range(0, 1) == 0)
						? $urandom() : 32'($urandom_range(1, 1 << 16));
					phase_cfg.full_flag       = 1'($urandom());
					phase_cfg.max_us_per_read = 16'($urandom());
				end
			endcase
			write_reg(rtcc_pkg::REG_INCREMENT,
				rtcc_pkg::CFG_DATA_W'(phase_cfg.increment));
			write_reg(rtcc_pkg::REG_RATE,
				rtcc_pkg::CFG_DATA_W'(phase_cfg.ticks_per_us_q8));
			write_reg(rtcc_pkg::REG_FULL,
				rtcc_pkg::CFG_DATA_W'(phase_cfg.full_flag));
			write_reg(rtcc_pkg::REG_CAP,
				rtcc_pkg::CFG_DATA_W'(phase_cfg.max_us_per_read));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase_cfg.increment == '0)
					r.func = ($urandom_range(0, 3) != 0)
						? rtcc_pkg::FUNC_READ : rtcc_pkg::FUNC_TICK;
				else
					r.func = ($urandom_range(0, 1) != 0)
						? rtcc_pkg::FUNC_READ : rtcc_pkg::FUNC_TICK;
				if (r.func == rtcc_pkg::FUNC_READ) begin
					pick = $urandom_range(0, 99);
					if (pick < 80) begin
						delta       = rtcc_pkg::HOST_W'($urandom_range(0, 1023))
							<< $urandom_range(0, 20);
						host_cursor = host_cursor + delta;
					end else if (pick < 90) begin
						host_cursor = {$urandom(), $urandom()};
					end else begin
						host_cursor = host_cursor
							- rtcc_pkg::HOST_W'($urandom_range(1, 1000));
					end
					r.host_ticks = host_cursor;
				end else begin
					r.host_ticks = {$urandom(), $urandom()};
				end
				if (burst_left == 0)
					burst_left = $urandom_range(1, 20);
				burst_left--;
				gap = 0;
				if (burst_left == 0)
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (n == ITEMS_PER_PHASE - 1 && gap == 0)
					gap = 1;
				send_request(r, gap, 1'b0, '0);
			end
		end

		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("realtime_clock_channel: match");
		else
			$display("realtime_clock_channel: mismatch");
		$finish;
	end

endmodule
